### sv/pppfc_pkg.sv
// Shared types and constants for the PPP frame collector.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package pppfc_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] PLUS_BYTE   = 8'h2B;
  localparam logic [7:0] HDR_ADDR    = 8'hFF;
  localparam logic [7:0] HDR_CTRL    = 8'h03;
  localparam logic [15:0] PROTO_LCP  = 16'hC021;
  localparam logic [15:0] PROTO_IPCP = 16'h8021;
  localparam logic [15:0] PROTO_IPV4 = 16'h0021;
  localparam logic [2:0] PLUS_MAX    = 3'd7;
  localparam logic [2:0] ESC_RUN_RST = 3'd3;
  localparam int unsigned HDR_BYTES  = 4;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_IDLE  = 2'd1,
    CMD_ENTER = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_DATA = 3'd0,
    KIND_GOOD = 3'd1,
    KIND_BAD  = 3'd2,
    KIND_OVF  = 3'd3,
    KIND_ESC  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CLS_LCP   = 2'd0,
    CLS_IPCP  = 2'd1,
    CLS_IPV4  = 2'd2,
    CLS_OTHER = 2'd3
  } class_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [8:0]  byte_index;
    logic [9:0]  frame_length;
    logic [15:0] protocol_word;
    logic [1:0]  protocol_class;
  } out_t;

  // Action record handed from the front to the back through the queue
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [8:0]  index;
    logic [9:0]  length;
    logic [15:0] proto;
  } act_t;

endpackage

### sv/pppfc_front.sv
// Front end: accepts requests, keeps mode, frame and plus-run state.
// Pushes one action record per result into the queue. Uses pppfc_pkg.
`timescale 1ns / 1ps

module pppfc_front #(
  parameter int unsigned FRAME_BYTES = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pppfc_pkg::in_t in_data_i,
  output logic           push_o,
  output pppfc_pkg::act_t push_data_o,
  input  logic           q_full_i
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);

  logic             active_q, active_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]       plus_q, plus_d;
  logic [2:0]       esc_run_q;
  logic [3:0][7:0]  hdr_q, hdr_d;
  logic             accept;
  logic             hdr_ok;
  logic [CNT_W+9:0] cnt_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_ext    = {10'd0, cnt_q};
  assign hdr_ok     = (cnt_q >= CNT_W'(pppfc_pkg::HDR_BYTES)) &&
                      (hdr_q[3] == pppfc_pkg::HDR_ADDR) &&
                      (hdr_q[2] == pppfc_pkg::HDR_CTRL);

  always_comb begin
    active_d    = active_q;
    cnt_d       = cnt_q;
    plus_d      = plus_q;
    hdr_d       = hdr_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept) begin
      unique case (in_data_i.cmd)
        pppfc_pkg::CMD_ENTER: begin
          if (!active_q) begin
            active_d = 1'b1;
            cnt_d    = '0;
            plus_d   = '0;
          end
        end
        pppfc_pkg::CMD_IDLE: begin
          if (active_q && (plus_q >= esc_run_q)) begin
            active_d         = 1'b0;
            push_o           = 1'b1;
            push_data_o.kind = pppfc_pkg::KIND_ESC;
          end
        end
        pppfc_pkg::CMD_BYTE: begin
          if (active_q) begin
            if (in_data_i.data_byte == pppfc_pkg::PLUS_BYTE) begin
              if (plus_q != pppfc_pkg::PLUS_MAX) begin
                plus_d = plus_q + 3'd1;
              end
            end else begin
              plus_d = '0;
              if (in_data_i.data_byte == pppfc_pkg::FLAG_BYTE) begin
                if (cnt_q != '0) begin
                  cnt_d              = '0;
                  push_o             = 1'b1;
                  push_data_o.length = cnt_ext[9:0];
                  if (hdr_ok) begin
                    push_data_o.kind  = pppfc_pkg::KIND_GOOD;
                    push_data_o.proto = {hdr_q[1], hdr_q[0]};
                  end else begin
                    push_data_o.kind  = pppfc_pkg::KIND_BAD;
                  end
                end
              end else if (cnt_q < CNT_W'(FRAME_BYTES)) begin
                if (cnt_q < CNT_W'(pppfc_pkg::HDR_BYTES)) begin
                  hdr_d[2'd3 - cnt_q[1:0]] = in_data_i.data_byte;
                end
                cnt_d             = cnt_q + CNT_W'(1);
                push_o            = 1'b1;
                push_data_o.kind  = pppfc_pkg::KIND_DATA;
                push_data_o.value = in_data_i.data_byte;
                push_data_o.index = cnt_ext[8:0];
              end else begin
                // frame too long: drop it and start again
                cnt_d            = '0;
                push_o           = 1'b1;
                push_data_o.kind = pppfc_pkg::KIND_OVF;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      plus_q    <= '0;
      hdr_q     <= '0;
      esc_run_q <= pppfc_pkg::ESC_RUN_RST;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      plus_q   <= plus_d;
      hdr_q    <= hdr_d;
      if (cfg_we_i) begin
        esc_run_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### sv/pppfc_queue.sv
// Short queue of action records between front and back.
// Flip-flop storage, one push and one pop per cycle. Uses pppfc_pkg.
`timescale 1ns / 1ps

module pppfc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pppfc_pkg::act_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output pppfc_pkg::act_t head_o,
  input  logic            pop_i
);

  pppfc_pkg::act_t mem_q [pppfc_pkg::QUEUE_DEPTH];
  logic [pppfc_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [pppfc_pkg::QCNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == pppfc_pkg::QCNT_W'(pppfc_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + pppfc_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + pppfc_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + pppfc_pkg::QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - pppfc_pkg::QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/pppfc_back.sv
// Back end: takes action records from the queue, classifies the protocol
// and holds the result in the output register. Uses pppfc_pkg.
`timescale 1ns / 1ps

module pppfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  pppfc_pkg::act_t q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pppfc_pkg::out_t out_data_o
);

  logic            valid_q;
  pppfc_pkg::out_t data_q, data_d;
  pppfc_pkg::class_e cls;

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    priority if (q_head_i.proto == pppfc_pkg::PROTO_LCP) begin
      cls = pppfc_pkg::CLS_LCP;
    end else if (q_head_i.proto == pppfc_pkg::PROTO_IPCP) begin
      cls = pppfc_pkg::CLS_IPCP;
    end else if (q_head_i.proto == pppfc_pkg::PROTO_IPV4) begin
      cls = pppfc_pkg::CLS_IPV4;
    end else begin
      cls = pppfc_pkg::CLS_OTHER;
    end
  end

  always_comb begin
    data_d              = '0;
    data_d.kind         = q_head_i.kind;
    data_d.byte_value   = q_head_i.value;
    data_d.byte_index   = q_head_i.index;
    data_d.frame_length = q_head_i.length;
    if (q_head_i.kind == pppfc_pkg::KIND_GOOD) begin
      data_d.protocol_word  = q_head_i.proto;
      data_d.protocol_class = cls;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

### sv/ppp_frame_collector_with_escape_core.sv
// Top level of the PPP frame collector with plus-run escape detection.
// Instantiates pppfc_front, pppfc_queue and pppfc_back; uses pppfc_pkg.
`timescale 1ns / 1ps

// The block takes one request per clock while in_ready_o is high: a received
// link byte, an idle tick or an enter-data-mode command, and gives at most
// one result per request. Data bytes come out with their index in the frame,
// a flag closes a non-empty frame with its length, header verdict and
// protocol class, a byte beyond FRAME_BYTES drops the frame with an overflow
// result, and a run of at least escape_plus_run '+' bytes followed by an
// idle tick reports escape and leaves data mode. '+' bytes never enter
// frames; no 0x7D unstuffing. Throughput is one request per cycle while the
// queue is not full, set by the front end's update of its running counters.
// A result is pushed into the queue at the edge that accepts its request and
// moves on into the output register when that register is empty or read.
// A two-entry queue plus the output register absorb a stalled sink; in_ready_o
// drops only when the queue is full. Write escape_plus_run only while idle.
module ppp_frame_collector_with_escape_core #(
  parameter int unsigned FRAME_BYTES = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration: escape_plus_run
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_wdata_i,
  // request channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pppfc_pkg::in_t  in_data_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pppfc_pkg::out_t out_data_o
);

  logic            push, q_full, q_valid, q_pop;
  pppfc_pkg::act_t push_data, q_head;

  // front: mode, frame count, plus run and header capture
  pppfc_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  // decoupling queue
  pppfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  // back: protocol class and output register
  pppfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for ppp_frame_collector_with_escape_core.
// Depends on pppfc_pkg and the core; a queue-fed driver and a monitor with
// its own deframer prediction check every result field by field.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAME_CAP    = 512;
  localparam logic [1:0]  CMD_SPARE    = 2'd3;   // unused command code
  localparam int unsigned SETTLE_CYCS  = 6;      // margin past the last request
  localparam int unsigned CYCLE_LIMIT  = 600000;

  // ---------------------------------------------------------------------------
  // Clock, reset and block I/O
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic            cfg_we_i    = 1'b0;
  logic [2:0]      cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  pppfc_pkg::in_t  in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  pppfc_pkg::out_t out_data_o;

  always #4 clk_i = ~clk_i;

  ppp_frame_collector_with_escape_core #(
    .FRAME_BYTES(FRAME_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  pppfc_pkg::in_t  link_q[$];     // link requests waiting to be driven
  pppfc_pkg::out_t deframe_q[$];  // deframer results still owed by the block
  int   queued_cnt = 0;   // requests ever pushed to link_q
  int   taken_cnt  = 0;   // requests accepted by the block
  int   err_cnt    = 0;
  int   cycle_cnt  = 0;
  int   kind_seen[5];
  bit   req_taken  = 1'b0; // request accepted at the last rising edge
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;

  // Predictor copy of the block's state and of escape_plus_run
  bit          dm_on       = 1'b0;
  logic [9:0]  frm_len     = '0;
  logic [2:0]  plus_cnt    = '0;
  logic [31:0] hdr_word    = '0;
  logic [2:0]  esc_run_cfg = pppfc_pkg::ESC_RUN_RST;

  // ---------------------------------------------------------------------------
  // Deframer prediction: one request in, at most one result out
  // ---------------------------------------------------------------------------
  task automatic deframe(input pppfc_pkg::in_t req, output bit has_res,
                         output pppfc_pkg::out_t res);
    logic [1:0]  cmd;
    logic [7:0]  b;
    logic [15:0] proto;
    int          pos;
    cmd     = req.cmd;
    b       = req.data_byte;
    has_res = 1'b0;
    res     = '0;
    if (cmd == pppfc_pkg::CMD_ENTER) begin
      // ignored when already in data mode
      if (!dm_on) begin
        dm_on    = 1'b1;
        frm_len  = '0;
        plus_cnt = '0;
      end
    end else if (cmd == pppfc_pkg::CMD_IDLE && dm_on) begin
      if (plus_cnt >= esc_run_cfg) begin
        dm_on    = 1'b0;
        has_res  = 1'b1;
        res.kind = pppfc_pkg::KIND_ESC;
      end
    end else if (cmd == pppfc_pkg::CMD_BYTE && dm_on) begin
      if (b == pppfc_pkg::PLUS_BYTE) begin
        if (plus_cnt != pppfc_pkg::PLUS_MAX) plus_cnt = plus_cnt + 3'd1;
      end else begin
        plus_cnt = '0;
        if (b == pppfc_pkg::FLAG_BYTE) begin
          // an empty frame closes silently
          if (frm_len != '0) begin
            has_res          = 1'b1;
            res.frame_length = frm_len;
            if (frm_len >= 10'(pppfc_pkg::HDR_BYTES) &&
                hdr_word[31:24] == pppfc_pkg::HDR_ADDR &&
                hdr_word[23:16] == pppfc_pkg::HDR_CTRL) begin
              proto             = hdr_word[15:0];
              res.kind          = pppfc_pkg::KIND_GOOD;
              res.protocol_word = proto;
              if (proto == pppfc_pkg::PROTO_LCP)
                res.protocol_class = pppfc_pkg::CLS_LCP;
              else if (proto == pppfc_pkg::PROTO_IPCP)
                res.protocol_class = pppfc_pkg::CLS_IPCP;
              else if (proto == pppfc_pkg::PROTO_IPV4)
                res.protocol_class = pppfc_pkg::CLS_IPV4;
              else
                res.protocol_class = pppfc_pkg::CLS_OTHER;
            end else begin
              res.kind = pppfc_pkg::KIND_BAD;
            end
            frm_len = '0;
          end
        end else if (frm_len < 10'(FRAME_CAP)) begin
          pos = int'(frm_len);
          if (frm_len < 10'(pppfc_pkg::HDR_BYTES)) hdr_word[(3 - pos) * 8 +: 8] = b;
          has_res        = 1'b1;
          res.kind       = pppfc_pkg::KIND_DATA;
          res.byte_value = b;
          res.byte_index = frm_len[8:0];
          frm_len        = frm_len + 10'd1;
        end else begin
          // buffer full: frame dropped, collection restarts
          frm_len  = '0;
          has_res  = 1'b1;
          res.kind = pppfc_pkg::KIND_OVF;
        end
      end
    end
    // CMD_SPARE, and anything but CMD_ENTER while in command mode: no effect
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new request at the falling edge once the last one is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (link_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= link_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: results checked, accepted requests fed to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit              has_res;
    pppfc_pkg::out_t res;
    pppfc_pkg::out_t want;
    req_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (out_data_o.kind <= pppfc_pkg::KIND_ESC) kind_seen[out_data_o.kind]++;
      if (deframe_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d", out_data_o.kind));
      end else begin
        want = deframe_q.pop_front();
        compare_field("kind", int'(out_data_o.kind), int'(want.kind));
        compare_field("byte_value", int'(out_data_o.byte_value),
                      int'(want.byte_value));
        compare_field("byte_index", int'(out_data_o.byte_index),
                      int'(want.byte_index));
        compare_field("frame_length", int'(out_data_o.frame_length),
                      int'(want.frame_length));
        compare_field("protocol_word", int'(out_data_o.protocol_word),
                      int'(want.protocol_word));
        compare_field("protocol_class", int'(out_data_o.protocol_class),
                      int'(want.protocol_class));
      end
    end
    if (req_taken) begin
      taken_cnt++;
      deframe(in_data_i, has_res, res);
      if (has_res) deframe_q.push_back(res);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               deframe_q.size());
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_req(input logic [1:0] cmd, input logic [7:0] b);
    pppfc_pkg::in_t r;
    r.cmd       = cmd;
    r.data_byte = b;
    link_q.push_back(r);
    queued_cnt++;
  endtask

  // Byte that is neither a flag nor a plus
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == pppfc_pkg::FLAG_BYTE || b == pppfc_pkg::PLUS_BYTE);
    return b;
  endfunction

  // Sender holds off until every request is taken and every result is back;
  // the extra cycles cover requests still in flight that give no result.
  task automatic settle();
    while (link_q.size() != 0 || taken_cnt != queued_cnt) @(posedge clk_i);
    while (deframe_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCS) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_run(input logic [2:0] run);
    cfg_wdata_i = run;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    esc_run_cfg = run;
  endtask

  // Full-size frame: long_mode 1 fills the buffer exactly, 2 overruns it
  task automatic add_long_frame(input int long_mode);
    int n;
    n = (long_mode == 1) ? FRAME_CAP : FRAME_CAP + 1 + $urandom_range(0, 2);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);   // close whatever was open
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_ADDR);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_CTRL);
    for (int i = 2; i < n; i++) add_req(pppfc_pkg::CMD_BYTE, plain_byte());
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);
  endtask

  // Mostly well-formed frames with random content, plus escape attempts,
  // broken headers and raw noise.
  task automatic add_traffic(input int n_items, input int long_mode);
    int          start;
    int          pick;
    logic [15:0] proto;
    start = queued_cnt;
    add_req(pppfc_pkg::CMD_ENTER, 8'($urandom_range(0, 255)));
    if (long_mode != 0) add_long_frame(long_mode);
    while (queued_cnt - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 4))
          0:       proto = pppfc_pkg::PROTO_LCP;
          1:       proto = pppfc_pkg::PROTO_IPCP;
          2:       proto = pppfc_pkg::PROTO_IPV4;
          default: proto = 16'($urandom_range(0, 65535));
        endcase
        add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_ADDR);
        add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_CTRL);
        add_req(pppfc_pkg::CMD_BYTE, proto[15:8]);
        add_req(pppfc_pkg::CMD_BYTE, proto[7:0]);
        repeat ($urandom_range(0, 12))
          add_req(pppfc_pkg::CMD_BYTE,
                  ($urandom_range(0, 15) == 0) ? pppfc_pkg::PLUS_BYTE : plain_byte());
        add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);
      end else if (pick < 67) begin
        // header left to chance, mostly bad
        repeat ($urandom_range(1, 6))
          add_req(pppfc_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
        add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);
      end else if (pick < 80) begin
        // plus run of any length, usually followed by an idle tick
        repeat ($urandom_range(0, 9)) add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PLUS_BYTE);
        if ($urandom_range(0, 3) != 0)
          add_req(pppfc_pkg::CMD_IDLE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) != 0) add_req(pppfc_pkg::CMD_BYTE, plain_byte());
        add_req(pppfc_pkg::CMD_ENTER, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4))
          add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        add_req(pppfc_pkg::CMD_IDLE, 8'($urandom_range(0, 255)));
      end else begin
        add_req(pppfc_pkg::CMD_ENTER, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [2:0] run_set[6] = '{3'd7, 3'd1, 3'd0, 3'd5, 3'd2, 3'd7};
  int         long_set[6] = '{0, 1, 0, 2, 0, 0};

  initial begin
    snd_idle_pct = 22;
    rcv_idle_pct = 74;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: command mode ignores bytes, ticks and the spare command
    add_req(pppfc_pkg::CMD_BYTE, 8'h55);
    add_req(pppfc_pkg::CMD_IDLE, 8'h00);
    add_req(CMD_SPARE, 8'hFF);
    add_req(pppfc_pkg::CMD_ENTER, 8'h00);
    add_req(pppfc_pkg::CMD_ENTER, 8'hFF);          // already active: no effect
    // LCP frame with a good header
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_ADDR);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_CTRL);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PROTO_LCP[15:8]);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PROTO_LCP[7:0]);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);  // empty frame, nothing reported
    // IPv4 frame with a plus byte inside, which stays out of the frame
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_ADDR);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_CTRL);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PLUS_BYTE);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PROTO_IPV4[15:8]);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PROTO_IPV4[7:0]);
    add_req(CMD_SPARE, 8'h00);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);
    // short frame: bad header
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_ADDR);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::HDR_CTRL);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::FLAG_BYTE);
    // run of two under the reset setting, kept across the tick, then escape
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PLUS_BYTE);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PLUS_BYTE);
    add_req(pppfc_pkg::CMD_IDLE, 8'h00);
    add_req(pppfc_pkg::CMD_BYTE, pppfc_pkg::PLUS_BYTE);
    add_req(pppfc_pkg::CMD_IDLE, 8'h00);
    settle();

    // Random traffic across register settings, idle patterns switching
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        snd_idle_pct = 74;
        rcv_idle_pct = 22;
      end else if (seg == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_run(run_set[seg]);
      add_traffic(40, long_set[seg]);
      settle();                         // sender waits for every result
      add_traffic(40, 0);
      settle();
    end

    $display("%0d link requests accepted in %0d cycles; escape runs 0, 1, 2, 3, 5, 7",
             taken_cnt, cycle_cnt);
    $display("results: %0d data, %0d good, %0d bad header, %0d overflow, %0d escape",
             kind_seen[pppfc_pkg::KIND_DATA], kind_seen[pppfc_pkg::KIND_GOOD],
             kind_seen[pppfc_pkg::KIND_BAD], kind_seen[pppfc_pkg::KIND_OVF],
             kind_seen[pppfc_pkg::KIND_ESC]);
    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
